// File: sv/mctt_pkg.sv
// Package for the multi-channel tick timer bank.
// Holds the word formats, the opcode and sequencer codes and the timer record.
// No dependencies.
package mctt_pkg;

    localparam int OP_W   = 3;
    localparam int ID_W   = 4;
    localparam int SECS_W = 16;
    localparam int CNT_W  = 24;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_START   = 3'd2,
        OP_RESTART = 3'd3,
        OP_STOP    = 3'd4,
        OP_SETPER  = 3'd5,
        OP_QUERY   = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DIV_CNT,
        S_DIV_PER,
        S_RESP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ID_W-1:0]   timer_id;
        logic              reload_mode;
        logic [SECS_W-1:0] period_secs;
    } t_cmd;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   which_timer;
        logic              expired;
        logic              is_running;
        logic [SECS_W-1:0] remaining_secs;
        logic [SECS_W-1:0] count_secs;
        logic [SECS_W-1:0] period_out_secs;
        logic              last;
    } t_rsp;

    typedef struct packed {
        logic             run;
        logic             reload;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] per;
    } t_timer;

endpackage

// File: sv/mctt_if.sv
// Valid/ready channel interface used for the command and result words.
// The payload type is set where the interface is instantiated; no dependencies.
interface mctt_if #(
    parameter type T_PAYLOAD = logic
);
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/mctt_div.sv
// Shared divider: a 24-bit counter value divided by the tick rate.
// One reciprocal multiplication, quotient ready the cycle after start. Depends on mctt_pkg.
module mctt_div #(
    parameter int TICKS_PER_SEC = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mctt_pkg::CNT_W-1:0] i_dividend,
    output logic                       o_done,
    output logic [mctt_pkg::SECS_W-1:0] o_quot
);
    // With the shift set to the dividend width plus the divisor's bit count,
    // the rounded-up reciprocal gives the exact floor for every dividend.
    localparam int SH    = mctt_pkg::CNT_W + $clog2(TICKS_PER_SEC);
    localparam int RCPW  = mctt_pkg::CNT_W + 1;
    localparam int PRODW = mctt_pkg::CNT_W + RCPW;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SH) + 64'(TICKS_PER_SEC) - 64'd1) / 64'(TICKS_PER_SEC);
    localparam logic [RCPW-1:0] RECIP = RECIP_FULL[RCPW-1:0];

    logic             r_done;
    logic [PRODW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PRODW'(i_dividend) * PRODW'(RECIP);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_prod[SH +: mctt_pkg::SECS_W];
endmodule

// File: sv/mctt_bank.sv
// Timer state store: run flag, reload flag, counter and period per timer.
// One read/write port at a single index. Depends on mctt_pkg.
module mctt_bank #(
    parameter int NUM_TIMERS = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [((NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1)-1:0] i_idx,
    input  logic                i_we,
    input  mctt_pkg::t_timer    i_wdata,
    output mctt_pkg::t_timer    o_rdata
);
    mctt_pkg::t_timer r_tmr [NUM_TIMERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_tmr[i] <= '0;
            end
        end else if (i_we) begin
            r_tmr[i_idx] <= i_wdata;
        end
    end

    assign o_rdata = r_tmr[i_idx];
endmodule

// File: sv/multi_channel_tick_timer_bank.sv
// Top level of the multi-channel tick timer bank: sequencer, result register.
// Depends on mctt_pkg, mctt_if, mctt_bank and mctt_div.
//
// Usage. Commands arrive as words on i_cmd (valid/ready) and results leave
// as words on o_rsp (valid/ready). A word is taken when valid and ready are
// both high at a rising edge. Every command gives at least one result word,
// and the final one carries last=1. A tick gives one word per expired timer,
// in timer order, or a single empty word when no timer expired.
// Timing. The block works on one command at a time; i_cmd.ready is high only
// while the sequencer is idle. Start, restart, stop, set period and create
// pass through the execute and response states before the result word is
// loaded. A tick walks the timers one per cycle through the single bank
// port, then loads one word per expiry from the emit state. A query runs
// the counter and then the period through the shared reciprocal-multiply
// divider before its result word is loaded.
// The result register decouples the two sides: a new command is accepted
// while a finished word still waits, and a stalled receiver only holds the
// sequencer when it has the next word ready to load.
// Reset (synchronous, active low) stops all timers, makes them one-shot,
// clears counters, periods and the allocation count, and empties the
// result register.
module multi_channel_tick_timer_bank #(
    parameter int NUM_TIMERS    = 10,
    parameter int TICKS_PER_SEC = 10
) (
    input logic   i_clk,
    input logic   i_rst_n,
    mctt_if.sink  i_cmd,
    mctt_if.source o_rsp
);
    localparam int IDXW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SLW  = $clog2(NUM_TIMERS + 1);
    localparam int CW   = mctt_pkg::CNT_W;

    mctt_pkg::t_state r_state, n_state;

    logic [mctt_pkg::OP_W-1:0]   r_op, n_op;
    logic [mctt_pkg::ID_W-1:0]   r_id, n_id;
    logic                        r_mode, n_mode;
    logic [mctt_pkg::SECS_W-1:0] r_secs, n_secs;
    logic [IDXW-1:0]             r_idx, n_idx;
    logic [SLW-1:0]              r_slots, n_slots;
    logic [NUM_TIMERS-1:0]       r_mask, n_mask;
    logic [mctt_pkg::SECS_W-1:0] r_cq, n_cq;
    mctt_pkg::t_rsp              r_res, n_res;
    mctt_pkg::t_rsp              r_out, n_out;
    logic                        r_out_vld, n_out_vld;

    mctt_pkg::t_timer bank_rd;
    mctt_pkg::t_timer bank_wd;
    logic             bank_we;
    logic             div_start;
    logic [CW-1:0]    div_dvd;
    logic             div_done;
    logic [mctt_pkg::SECS_W-1:0] div_quot;

    logic                  in_acc;
    logic                  can_load;
    logic                  load;
    logic                  id_ok;
    logic                  slot_free;
    logic [CW-1:0]         dec_cnt;
    logic [CW-1:0]         per_ticks;
    logic [IDXW-1:0]       low_idx;
    logic [NUM_TIMERS-1:0] low_bit;
    logic                  emit_last;

    mctt_bank #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_idx   (r_idx),
        .i_we    (bank_we),
        .i_wdata (bank_wd),
        .o_rdata (bank_rd)
    );

    mctt_div #(
        .TICKS_PER_SEC (TICKS_PER_SEC)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // The command is only taken while idle; the result register may be full.
    assign i_cmd.ready = (r_state == mctt_pkg::S_IDLE);
    assign in_acc      = i_cmd.valid && i_cmd.ready;
    assign can_load    = !r_out_vld || o_rsp.ready;

    assign id_ok     = 32'(r_id) < NUM_TIMERS;
    assign slot_free = 32'(r_slots) < NUM_TIMERS;
    assign dec_cnt   = (bank_rd.cnt != '0) ? bank_rd.cnt - 1'b1 : '0;
    assign per_ticks = CW'({8'b0, r_secs} * CW'(TICKS_PER_SEC));

    // Lowest pending expiry, and whether it is the final one of the tick.
    always_comb begin
        low_idx = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = IDXW'(i);
            end
        end
    end
    assign low_bit   = r_mask & (~r_mask + 1'b1);
    assign emit_last = (r_mask & ~low_bit) == '0;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mctt_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_cmd.payload.opcode == mctt_pkg::OP_TICK) ?
                              mctt_pkg::S_WALK : mctt_pkg::S_EXEC;
                end
            end
            mctt_pkg::S_EXEC: begin
                if ((r_op == mctt_pkg::OP_QUERY) && id_ok) begin
                    n_state = mctt_pkg::S_DIV_CNT;
                end else begin
                    n_state = mctt_pkg::S_RESP;
                end
            end
            mctt_pkg::S_WALK: begin
                if (32'(r_idx) == NUM_TIMERS - 1) begin
                    n_state = mctt_pkg::S_EMIT;
                end
            end
            mctt_pkg::S_DIV_CNT: begin
                if (div_done) begin
                    n_state = mctt_pkg::S_DIV_PER;
                end
            end
            mctt_pkg::S_DIV_PER: begin
                if (div_done) begin
                    n_state = mctt_pkg::S_RESP;
                end
            end
            mctt_pkg::S_RESP: begin
                if (can_load) begin
                    n_state = mctt_pkg::S_IDLE;
                end
            end
            mctt_pkg::S_EMIT: begin
                if (can_load && ((r_mask == '0) || emit_last)) begin
                    n_state = mctt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mctt_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and output logic of the sequencer.
    always_comb begin
        n_op      = r_op;
        n_id      = r_id;
        n_mode    = r_mode;
        n_secs    = r_secs;
        n_idx     = r_idx;
        n_slots   = r_slots;
        n_mask    = r_mask;
        n_cq      = r_cq;
        n_res     = r_res;
        n_out     = r_out;
        bank_we   = 1'b0;
        bank_wd   = bank_rd;
        div_start = 1'b0;
        div_dvd   = bank_rd.cnt;
        load      = 1'b0;

        case (r_state)
            mctt_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_op   = i_cmd.payload.opcode;
                    n_id   = i_cmd.payload.timer_id;
                    n_mode = i_cmd.payload.reload_mode;
                    n_secs = i_cmd.payload.period_secs;
                    n_mask = '0;
                    case (i_cmd.payload.opcode)
                        mctt_pkg::OP_TICK:   n_idx = '0;
                        mctt_pkg::OP_CREATE: n_idx = IDXW'(r_slots);
                        default:             n_idx = IDXW'(i_cmd.payload.timer_id);
                    endcase
                end
            end
            mctt_pkg::S_EXEC: begin
                n_res      = '0;
                n_res.last = 1'b1;
                n_res.ok   = id_ok;
                n_res.which_timer = r_id;
                case (r_op)
                    mctt_pkg::OP_CREATE: begin
                        n_res.ok = slot_free;
                        if (slot_free) begin
                            n_res.which_timer = mctt_pkg::ID_W'(r_slots);
                            bank_we        = 1'b1;
                            bank_wd.reload = r_mode;
                            n_slots        = r_slots + 1'b1;
                        end else begin
                            n_res.which_timer = '0;
                        end
                    end
                    mctt_pkg::OP_START: begin
                        bank_we     = id_ok;
                        bank_wd.run = 1'b1;
                    end
                    mctt_pkg::OP_RESTART: begin
                        bank_we     = id_ok;
                        bank_wd.run = 1'b1;
                        bank_wd.cnt = bank_rd.per;
                    end
                    mctt_pkg::OP_STOP: begin
                        bank_we     = id_ok;
                        bank_wd.run = 1'b0;
                    end
                    mctt_pkg::OP_SETPER: begin
                        bank_we     = id_ok;
                        bank_wd.per = per_ticks;
                        bank_wd.cnt = per_ticks;
                    end
                    mctt_pkg::OP_QUERY: begin
                        div_start = id_ok;
                        div_dvd   = bank_rd.cnt;
                    end
                    default: begin
                        n_res.ok = 1'b0;
                    end
                endcase
            end
            mctt_pkg::S_WALK: begin
                // One timer per cycle: count down, and reload or stop at zero.
                if (bank_rd.run) begin
                    bank_we     = 1'b1;
                    bank_wd.cnt = dec_cnt;
                    if (dec_cnt == '0) begin
                        n_mask[r_idx] = 1'b1;
                        if (bank_rd.reload) begin
                            bank_wd.cnt = bank_rd.per;
                        end else begin
                            bank_wd.run = 1'b0;
                        end
                    end
                end
                if (32'(r_idx) != NUM_TIMERS - 1) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            mctt_pkg::S_DIV_CNT: begin
                if (div_done) begin
                    n_cq      = div_quot;
                    div_start = 1'b1;
                    div_dvd   = bank_rd.per;
                end
            end
            mctt_pkg::S_DIV_PER: begin
                if (div_done) begin
                    n_res.is_running      = bank_rd.run;
                    n_res.remaining_secs  = bank_rd.run ? r_cq : '0;
                    n_res.count_secs      = r_cq;
                    n_res.period_out_secs = div_quot;
                end
            end
            mctt_pkg::S_RESP: begin
                if (can_load) begin
                    load  = 1'b1;
                    n_out = r_res;
                end
            end
            mctt_pkg::S_EMIT: begin
                if (can_load) begin
                    load       = 1'b1;
                    n_out      = '0;
                    n_out.ok   = 1'b1;
                    n_out.last = 1'b1;
                    if (r_mask != '0) begin
                        n_out.which_timer = mctt_pkg::ID_W'(low_idx);
                        n_out.expired     = 1'b1;
                        n_out.last        = emit_last;
                        n_mask            = r_mask & ~low_bit;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign n_out_vld = load ? 1'b1 : (o_rsp.ready ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mctt_pkg::S_IDLE;
            r_slots   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slots   <= n_slots;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_id   <= n_id;
        r_mode <= n_mode;
        r_secs <= n_secs;
        r_idx  <= n_idx;
        r_mask <= n_mask;
        r_cq   <= n_cq;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_rsp.valid   = r_out_vld;
    assign o_rsp.payload = r_out;

    // The allocation count never passes the number of timers.
    a_slots_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slots) <= NUM_TIMERS)
        else $error("allocation count beyond the bank size");

    // A tick starts its walk at the first timer with no expiry pending.
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_cmd.payload.opcode == mctt_pkg::OP_TICK)) |=>
        (r_state == mctt_pkg::S_WALK) && (r_idx == '0) && (r_mask == '0))
        else $error("tick walk did not start cleanly");

    // An expiry word always reports success and never carries query fields.
    a_expiry_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.expired) |->
        (r_out.ok && !r_out.is_running && (r_out.count_secs == '0)))
        else $error("malformed expiry word");

    // Loading the final word of a command returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_out.last) |=> (r_state == mctt_pkg::S_IDLE))
        else $error("sequencer busy after the final word");

    // The second division result closes a query.
    a_query_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == mctt_pkg::S_DIV_PER) && div_done) |=>
        (r_state == mctt_pkg::S_RESP) && r_res.ok && r_res.last)
        else $error("query did not finish after the period division");
endmodule
